// ===== hdl/i2cmpg_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmpg_pkg: shared types and constants of the I2C master phase generator
// Command codes, field widths and the phase indexes that end each command.
// ----------------------------------------------------------------------------
package i2cmpg_pkg;

  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int LINE_W  = BYTE_W + 1;
  localparam int PHASE_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_SEND_ACK = 3'd4,
    OP_READ_ACK = 3'd5
  } op_t;

  typedef logic [PHASE_W-1:0] phase_idx_t;

  localparam phase_idx_t IDX_FIRST      = 5'd0;
  localparam phase_idx_t IDX_PAIR_LAST  = 5'd1;
  localparam phase_idx_t IDX_START_LAST = 5'd2;
  localparam phase_idx_t IDX_READ_LAST  = 5'd15;
  localparam phase_idx_t IDX_ACK_HIGH   = 5'd16;
  localparam phase_idx_t IDX_WRITE_LAST = 5'd17;

endpackage

// ===== hdl/i2cmpg_if.sv =====
// ----------------------------------------------------------------------------
// i2cmpg_if: command and phase channels of the I2C master phase generator
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface i2cmpg_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [i2cmpg_pkg::OP_W-1:0]      op;
  logic [i2cmpg_pkg::BYTE_W-1:0]    tx_byte;
  logic                             ack_bit;
  logic [i2cmpg_pkg::LINE_W-1:0]    line_bits;

  modport source (output valid, output op, output tx_byte, output ack_bit,
                  output line_bits, input ready);
  modport sink   (input valid, input op, input tx_byte, input ack_bit,
                  input line_bits, output ready);
endinterface

interface i2cmpg_phase_if;
  logic                             valid;
  logic                             ready;
  logic                             scl;
  logic                             sda_out;
  logic [i2cmpg_pkg::BYTE_W-1:0]    rx_byte;
  logic                             ack_in;
  logic                             last;

  modport source (output valid, output scl, output sda_out, output rx_byte,
                  output ack_in, output last, input ready);
  modport sink   (input valid, input scl, input sda_out, input rx_byte,
                  input ack_in, input last, output ready);
endinterface

// ===== hdl/i2c_master_phase_generator_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_phase_generator_unit: I2C master command to bus phase sequencer
//
// Usage: each word on the cmd channel is one bus command (start, stop, write
// byte, read byte, send ack, read ack). It expands into the phases the command
// needs, one word per phase on the phase channel, each giving the SCL level
// and SDA drive held for one half-period. The word with last set closes the
// command. rx_byte carries the read byte on the last phase of read byte and
// ack_in the sampled acknowledge on the last phase of write byte and read ack.
// Unused command codes are taken and produce no phase.
// A taken command is latched into the command holder; its phases then pass
// through the output register, one phase per cycle while the receiver does not
// stall. A command has 2, 3, 16 or 18 phases. The next command is taken in the
// cycle its predecessor's last phase enters the output register, so phases of
// consecutive commands follow without a gap.
// Reset clears the busy flag, the phase index and the output valid flag; no
// phase is pending afterwards. A stalled receiver freezes the phase counter
// and the output register; cmd.ready stays low until the last phase can move.
// ----------------------------------------------------------------------------
module i2c_master_phase_generator_unit (
  input  logic                  clk,
  input  logic                  rst,
  i2cmpg_cmd_if.sink            cmd,
  i2cmpg_phase_if.source        phase
);
  import i2cmpg_pkg::*;

  op_t                op_q;
  logic [BYTE_W-1:0]  tx_q;
  logic               ab_q;
  logic [LINE_W-1:0]  lines_q;
  logic               busy;
  phase_idx_t         idx;

  logic               out_valid;
  logic               scl_q;
  logic               sda_q;
  logic [BYTE_W-1:0]  rx_q;
  logic               ack_q;
  logic               last_q;

  logic               ph_scl;
  logic               ph_sda;
  logic [BYTE_W-1:0]  ph_rx;
  logic               ph_ack;
  logic               ph_last;
  logic [BYTE_W-1:0]  tx_sh;

  logic               adv;
  logic               step;
  logic               take;
  logic               cmd_known;

  // phase decode
  always_comb begin
    tx_sh   = tx_q << idx[3:1];
    ph_scl  = ~idx[0];
    ph_sda  = 1'b1;
    ph_rx   = '0;
    ph_ack  = 1'b0;
    ph_last = 1'b0;
    case (op_q)
      OP_START: begin
        ph_scl  = (idx != IDX_START_LAST);
        ph_sda  = (idx == IDX_FIRST);
        ph_last = (idx == IDX_START_LAST);
      end
      OP_STOP: begin
        ph_scl  = 1'b1;
        ph_sda  = idx[0];
        ph_last = (idx == IDX_PAIR_LAST);
      end
      OP_WRITE: begin
        ph_sda  = (idx < IDX_ACK_HIGH) ? tx_sh[BYTE_W-1] : 1'b1;
        ph_last = (idx == IDX_WRITE_LAST);
        ph_ack  = ph_last & lines_q[0];
      end
      OP_READ: begin
        ph_last = (idx == IDX_READ_LAST);
        ph_rx   = ph_last ? lines_q[LINE_W-1:1] : '0;
      end
      OP_SEND_ACK: begin
        ph_sda  = ab_q;
        ph_last = (idx == IDX_PAIR_LAST);
      end
      OP_READ_ACK: begin
        ph_last = (idx == IDX_PAIR_LAST);
        ph_ack  = ph_last & lines_q[0];
      end
      default: begin
        ph_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    cmd_known = cmd.op inside {[OP_START:OP_READ_ACK]};
    adv       = ~out_valid | phase.ready;
    step      = busy & adv;
    cmd.ready = ~busy | (adv & ph_last);
    take      = cmd.valid & cmd.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= IDX_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (take) begin
        busy <= cmd_known;
        idx  <= IDX_FIRST;
      end else if (step) begin
        if (ph_last) begin
          busy <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  // command holder and output word
  always_ff @(posedge clk) begin
    if (take) begin
      op_q    <= op_t'(cmd.op);
      tx_q    <= cmd.tx_byte;
      ab_q    <= cmd.ack_bit;
      lines_q <= cmd.line_bits;
    end
    if (step) begin
      scl_q  <= ph_scl;
      sda_q  <= ph_sda;
      rx_q   <= ph_rx;
      ack_q  <= ph_ack;
      last_q <= ph_last;
    end
  end

  assign phase.valid   = out_valid;
  assign phase.scl     = scl_q;
  assign phase.sda_out = sda_q;
  assign phase.rx_byte = rx_q;
  assign phase.ack_in  = ack_q;
  assign phase.last    = last_q;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= IDX_WRITE_LAST)
    else $error("phase index beyond longest command");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (take && cmd_known) |=> busy && idx == IDX_FIRST)
    else $error("known command not started");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cmd.ready)
    else $error("idle sequencer refuses command");

  a_rx_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (rx_q != '0 || ack_q)) |-> last_q)
    else $error("read data or ack outside last phase");

  a_step_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("phase produced but not presented");

endmodule

// ===== bench/tb_i2c_master_phase_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_phase_generator_unit: self-checking bench for the phase unit
// Commands come from a directed table and then from random bus transactions
// with noise. Each taken command is expanded by a local model into its SCL/SDA
// phases, and every phase word that leaves the unit is compared with the
// oldest expected one. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_i2c_master_phase_generator_unit;
  import i2cmpg_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_BATCH = 44;
  localparam int NUM_ROWS = 23;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_bit;
    logic [LINE_W-1:0] line_bits;
    logic              typed;
    logic [BYTE_W-1:0] exp_rx;
    logic              exp_ack;
  } cmd_row_t;

  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_in;
    logic              last;
  } phase_word_t;

  // op, tx_byte, ack_bit, line_bits, typed, rx_byte, ack_in of the last phase
  localparam cmd_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_START,    8'h00, 1'b0, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE,    8'h00, 1'b0, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE,    8'hFF, 1'b1, 9'h1FF, 1'b1, 8'h00, 1'b1},
    '{OP_WRITE,    8'hA5, 1'b0, 9'h0AA, 1'b0, 8'h00, 1'b0},
    '{OP_READ_ACK, 8'h3C, 1'b0, 9'h001, 1'b1, 8'h00, 1'b1},
    '{OP_READ,     8'h00, 1'b1, 9'h1FF, 1'b1, 8'hFF, 1'b0},
    '{OP_SEND_ACK, 8'hFF, 1'b0, 9'h1FF, 1'b1, 8'h00, 1'b0},
    '{OP_READ,     8'hFF, 1'b0, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_SEND_ACK, 8'h00, 1'b1, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_READ,     8'h12, 1'b0, 9'h155, 1'b1, 8'hAA, 1'b0},
    '{OP_READ,     8'h34, 1'b1, 9'h0AB, 1'b1, 8'h55, 1'b0},
    '{OP_READ_ACK, 8'hC3, 1'b1, 9'h1FE, 1'b1, 8'h00, 1'b0},
    '{OP_STOP,     8'hFF, 1'b1, 9'h1FF, 1'b1, 8'h00, 1'b0},
    '{OP_SPARE_LO, 8'hFF, 1'b1, 9'h1FF, 1'b0, 8'h00, 1'b0},
    '{OP_SPARE_HI, 8'h00, 1'b0, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_START,    8'hFF, 1'b1, 9'h1FF, 1'b1, 8'h00, 1'b0},
    '{OP_WRITE,    8'h5A, 1'b1, 9'h1FE, 1'b0, 8'h00, 1'b0},
    '{OP_WRITE,    8'h80, 1'b0, 9'h001, 1'b1, 8'h00, 1'b1},
    '{OP_WRITE,    8'h01, 1'b1, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_STOP,     8'h00, 1'b0, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_STOP,     8'h7E, 1'b1, 9'h0F0, 1'b0, 8'h00, 1'b0},
    '{OP_START,    8'h81, 1'b0, 9'h10F, 1'b0, 8'h00, 1'b0},
    '{OP_START,    8'h00, 1'b1, 9'h000, 1'b0, 8'h00, 1'b0}
  };

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   err_count = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cmd_sent;
  phase_word_t bus_phase_q[$];
  phase_word_t got_word;
  phase_word_t want_word;

  i2cmpg_cmd_if   cmd_if ();
  i2cmpg_phase_if ph_if ();

  i2c_master_phase_generator_unit uut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .phase (ph_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void emit_phase(logic c, logic d, logic [BYTE_W-1:0] rx, logic ack,
                                     logic fin);
    phase_word_t w;
    w = '{c, d, rx, ack, fin};
    bus_phase_q.push_back(w);
  endfunction

  function automatic void expand_command(cmd_row_t w);
    logic [BYTE_W-1:0] sample_byte;
    logic              sample_ack;
    phase_word_t       tail;
    sample_byte = w.line_bits[LINE_W-1:1];
    sample_ack = w.line_bits[0];
    case (w.op)
      OP_START: begin
        emit_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        emit_phase(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        emit_phase(1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
      end
      OP_STOP: begin
        emit_phase(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        emit_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
      end
      OP_WRITE: begin
        for (int i = BYTE_W - 1; i >= 0; i--) begin
          emit_phase(1'b1, w.tx_byte[i], 8'h00, 1'b0, 1'b0);
          emit_phase(1'b0, w.tx_byte[i], 8'h00, 1'b0, 1'b0);
        end
        emit_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        emit_phase(1'b0, 1'b1, 8'h00, sample_ack, 1'b1);
      end
      OP_READ: begin
        for (int i = 0; i < BYTE_W; i++) begin
          emit_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
          emit_phase(1'b0, 1'b1, (i == BYTE_W - 1) ? sample_byte : 8'h00, 1'b0,
                     i == BYTE_W - 1);
        end
      end
      OP_SEND_ACK: begin
        emit_phase(1'b1, w.ack_bit, 8'h00, 1'b0, 1'b0);
        emit_phase(1'b0, w.ack_bit, 8'h00, 1'b0, 1'b1);
      end
      OP_READ_ACK: begin
        emit_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        emit_phase(1'b0, 1'b1, 8'h00, sample_ack, 1'b1);
      end
      default: ;
    endcase
    // typed rows pin the sampled fields of the closing phase
    if (w.typed && bus_phase_q.size() != 0) begin
      tail = bus_phase_q.pop_back();
      tail.rx_byte = w.exp_rx;
      tail.ack_in = w.exp_ack;
      bus_phase_q.push_back(tail);
    end
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic cmd_row_t random_word(logic [OP_W-1:0] op);
    cmd_row_t w;
    w.op = op;
    w.tx_byte = BYTE_W'($urandom_range(0, 255));
    w.ack_bit = 1'($urandom_range(0, 1));
    w.line_bits = LINE_W'($urandom_range(0, 511));
    w.typed = 1'b0;
    w.exp_rx = 8'h00;
    w.exp_ack = 1'b0;
    return w;
  endfunction

  task automatic send_word(cmd_row_t w);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op <= w.op;
    cmd_if.tx_byte <= w.tx_byte;
    cmd_if.ack_bit <= w.ack_bit;
    cmd_if.line_bits <= w.line_bits;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    expand_command(w);
    if (w.op <= OP_READ_ACK) cmd_sent++;
  endtask

  task automatic drain_phases();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (bus_phase_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_transaction();
    int n_xfer;
    send_word(random_word(OP_START));
    send_word(random_word(OP_WRITE));
    n_xfer = $urandom_range(1, 3);
    for (int k = 0; k < n_xfer; k++) begin
      case ($urandom_range(0, 3))
        0, 1: send_word(random_word(OP_WRITE));
        2: begin
          send_word(random_word(OP_READ));
          send_word(random_word(OP_SEND_ACK));
        end
        default: send_word(random_word(OP_READ_ACK));
      endcase
    end
    if ($urandom_range(0, 3) == 0) send_word(random_word(OP_START));
    send_word(random_word(OP_STOP));
  endtask

  task automatic send_random_batch(int count);
    int target;
    target = cmd_sent + count;
    while (cmd_sent < target) begin
      if ($urandom_range(0, 4) == 0) send_word(random_word(OP_W'($urandom_range(0, 7))));
      else send_transaction();
    end
  endtask

  always @(posedge clk) begin
    ph_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && ph_if.valid && ph_if.ready) begin
      got_word = '{ph_if.scl, ph_if.sda_out, ph_if.rx_byte, ph_if.ack_in, ph_if.last};
      if (bus_phase_q.size() == 0) begin
        note_error($sformatf("unexpected phase word scl=%b sda=%b rx=%h ack=%b last=%b",
                             got_word.scl, got_word.sda_out, got_word.rx_byte,
                             got_word.ack_in, got_word.last));
      end else begin
        want_word = bus_phase_q.pop_front();
        if (got_word.scl !== want_word.scl || got_word.sda_out !== want_word.sda_out ||
            got_word.rx_byte !== want_word.rx_byte || got_word.ack_in !== want_word.ack_in ||
            got_word.last !== want_word.last) begin
          note_error($sformatf(
            "phase mismatch: exp scl=%b sda=%b rx=%h ack=%b last=%b, got %b %b %h %b %b",
            want_word.scl, want_word.sda_out, want_word.rx_byte, want_word.ack_in,
            want_word.last, got_word.scl, got_word.sda_out, got_word.rx_byte,
            got_word.ack_in, got_word.last));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cmd_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cmd_if.valid = 1'b0;
    cmd_if.op = OP_START;
    cmd_if.tx_byte = '0;
    cmd_if.ack_bit = 1'b0;
    cmd_if.line_bits = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) send_word(DIRECTED_ROWS[r]);

    drain_phases();
    send_random_batch(RANDOM_BATCH);
    drain_phases();
    send_idle_pct = 88;
    send_random_batch(RANDOM_BATCH);
    drain_phases();
    send_idle_pct = 0;
    recv_stall_pct = 88;
    send_random_batch(RANDOM_BATCH);
    drain_phases();
    send_idle_pct = 15;
    recv_stall_pct = 15;
    send_random_batch(RANDOM_BATCH);

    drain_phases();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && bus_phase_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
